>>> rtl/yabd_pkg.sv
package yabd_pkg;

  // fixed geometry of the detection head
  localparam int MAX_GRID    = 80;
  localparam int NUM_CLASSES = 2;
  localparam int NUM_ANCHORS = 3;
  localparam int NUM_LEVELS  = 3;

  // sigmoid unit latency: table stage, five multiply stages, setup, 17 divide stages
  localparam int SIG_LAT = 24;

  // configuration port
  localparam int ADDR_W = 4;
  localparam logic [15:0] CONF_THR_RST = 16'd16384;
  localparam logic [15:0] SCALE_RST    = 16'd4096;

  typedef enum logic [1:0] {
    REG_CONF_THR = 2'd0,
    REG_SCALE_X  = 2'd1,
    REG_SCALE_Y  = 2'd2
  } reg_idx_t;

  // round(2^32 * exp(-2^k / 256)); bits 13 and up give zero
  localparam logic [31:0] EXP_BITS [13] = '{
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748382, 32'd3790295336, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260616,  32'd78665070,   32'd1440801,
    32'd483
  };

  // anchor sizes in pixels, indexed [level][slot]
  localparam logic [8:0] ANCHOR_W [3][3] = '{
    '{9'd10,  9'd16,  9'd33},
    '{9'd30,  9'd62,  9'd59},
    '{9'd116, 9'd156, 9'd373}
  };
  localparam logic [8:0] ANCHOR_H [3][3] = '{
    '{9'd13, 9'd30,  9'd23},
    '{9'd61, 9'd45,  9'd119},
    '{9'd90, 9'd198, 9'd326}
  };

  // exp(-m/256) in Q1.32 for the low eight magnitude bits, chained in bit order
  function automatic logic [32:0] lo_exp(input logic [7:0] m);
    logic [64:0] acc;
    logic [32:0] e;
    e = 33'h1_0000_0000;
    for (int k = 0; k < 8; k++) begin
      if (m[k]) begin
        acc = 65'(e) * 65'(EXP_BITS[k]) + 65'h0_8000_0000;
        e = acc[64:32];
      end
    end
    return e;
  endfunction

  typedef logic [255:0][32:0] lo_tab_t;

  function automatic lo_tab_t build_lo_tab();
    lo_tab_t tab;
    for (int i = 0; i < 256; i++) begin
      tab[i] = lo_exp(8'(i));
    end
    return tab;
  endfunction

  localparam lo_tab_t LO_TAB = build_lo_tab();

  typedef struct packed {
    logic [15:0] conf_threshold;
    logic [15:0] scale_x;
    logic [15:0] scale_y;
  } cfg_t;

  // side data that travels beside the sigmoid units
  typedef struct packed {
    logic       ok;
    logic [1:0] level;
    logic [8:0] aw;
    logic [8:0] ah;
    logic [6:0] row;
    logic [6:0] col;
  } meta_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] obj;
    logic [15:0] cls0;
    logic [15:0] cls1;
  } sig_set_t;

  typedef struct packed {
    logic signed [15:0] box_left;
    logic signed [15:0] box_top;
    logic signed [15:0] box_right;
    logic signed [15:0] box_bottom;
    logic        [15:0] confidence;
    logic               top_class;
    logic        [15:0] class_score;
  } det_t;

endpackage

>>> rtl/yabd_if.sv
interface yabd_pred_if;
  logic               valid;
  logic               ready;
  logic [1:0]         level;
  logic [1:0]         anchor_slot;
  logic [6:0]         cell_row;
  logic [6:0]         cell_col;
  logic signed [15:0] logit_x;
  logic signed [15:0] logit_y;
  logic signed [15:0] logit_w;
  logic signed [15:0] logit_h;
  logic signed [15:0] logit_obj;
  logic signed [15:0] logit_cls0;
  logic signed [15:0] logit_cls1;

  modport source (
    output valid, level, anchor_slot, cell_row, cell_col,
    output logit_x, logit_y, logit_w, logit_h, logit_obj, logit_cls0, logit_cls1,
    input  ready
  );
  modport sink (
    input  valid, level, anchor_slot, cell_row, cell_col,
    input  logit_x, logit_y, logit_w, logit_h, logit_obj, logit_cls0, logit_cls1,
    output ready
  );
endinterface

interface yabd_det_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_left;
  logic signed [15:0] box_top;
  logic signed [15:0] box_right;
  logic signed [15:0] box_bottom;
  logic        [15:0] confidence;
  logic               top_class;
  logic        [15:0] class_score;

  modport source (
    output valid, box_left, box_top, box_right, box_bottom,
    output confidence, top_class, class_score,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_top, box_right, box_bottom,
    input  confidence, top_class, class_score,
    output ready
  );
endinterface

>>> rtl/yabd_cfg.sv
module yabd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [yabd_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output yabd_pkg::cfg_t               cfg
);
  import yabd_pkg::*;

  logic [1:0] idx;

  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  // register writes on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.conf_threshold <= CONF_THR_RST;
      cfg.scale_x        <= SCALE_RST;
      cfg.scale_y        <= SCALE_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_CONF_THR: cfg.conf_threshold <= pwdata[15:0];
        REG_SCALE_X:  cfg.scale_x        <= pwdata[15:0];
        REG_SCALE_Y:  cfg.scale_y        <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_CONF_THR: prdata = {16'd0, cfg.conf_threshold};
      REG_SCALE_X:  prdata = {16'd0, cfg.scale_x};
      REG_SCALE_Y:  prdata = {16'd0, cfg.scale_y};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> rtl/yabd_sigmoid.sv
module yabd_sigmoid (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] raw,
  output logic [15:0] sig
);
  import yabd_pkg::*;

  localparam int MUL_N = 5;   // magnitude bits 8..12 need a multiply each
  localparam int QW    = 17;  // quotient bits
  localparam int DW    = 50;  // dividend width

  logic        neg_in;
  logic [15:0] mag_in;

  logic [32:0] e_pipe   [MUL_N+1];
  logic        neg_pipe [MUL_N+1];
  logic [7:0]  hi_pipe  [MUL_N];

  logic [33:0]   d_in;
  logic [DW-1:0] n_in;

  logic [DW-1:0] div_r [QW];
  logic [33:0]   div_d [QW];
  logic [QW-1:0] div_q [QW+1];

  // magnitude of the Q8.8 logit; the most negative code keeps 0x8000
  assign neg_in = raw[15];
  assign mag_in = neg_in ? 16'(~raw + 16'd1) : raw;

  // low eight bits straight from the constant table
  always_ff @(posedge clk) begin
    if (en) begin
      e_pipe[0]   <= LO_TAB[mag_in[7:0]];
      neg_pipe[0] <= neg_in;
      hi_pipe[0]  <= mag_in[15:8];
    end
  end

  // one rounded Q0.32 multiply per remaining magnitude bit
  for (genvar j = 0; j < MUL_N; j++) begin : g_mul
    logic [63:0] prod;
    logic [32:0] e_new;

    assign prod = 64'(e_pipe[j][31:0]) * 64'(EXP_BITS[8+j]) + 64'h8000_0000;

    always_comb begin
      e_new = e_pipe[j];
      if (hi_pipe[j][j]) begin
        if (e_pipe[j][32]) begin
          e_new = {1'b0, EXP_BITS[8+j]};
        end else begin
          e_new = {1'b0, prod[63:32]};
        end
      end
      // magnitudes of 32 and above underflow to zero
      if (j == MUL_N-1 && hi_pipe[j][7:5] != 3'd0) begin
        e_new = '0;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        e_pipe[j+1]   <= e_new;
        neg_pipe[j+1] <= neg_pipe[j];
      end
    end

    if (j < MUL_N-1) begin : g_hi
      always_ff @(posedge clk) begin
        if (en) begin
          hi_pipe[j+1] <= hi_pipe[j];
        end
      end
    end
  end

  // divisor 1 + e, rounded dividend
  assign d_in = 34'(e_pipe[MUL_N]) + (34'd1 << 32);
  assign n_in = (neg_pipe[MUL_N] ? {1'b0, e_pipe[MUL_N], 16'd0} : (50'd1 << 48))
                + {17'd0, d_in[33:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= n_in;
      div_d[0] <= d_in;
      div_q[0] <= '0;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int SH = QW - 1 - j;
    logic [DW-1:0] sub_d;
    logic          ge;

    assign sub_d = DW'(div_d[j]) << SH;
    assign ge    = div_r[j] >= sub_d;

    always_ff @(posedge clk) begin
      if (en) begin
        div_q[j+1] <= div_q[j] | (QW'(ge) << SH);
      end
    end

    if (j < QW-1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          div_r[j+1] <= ge ? div_r[j] - sub_d : div_r[j];
          div_d[j+1] <= div_d[j];
        end
      end
    end
  end

  // cap at just below one
  assign sig = div_q[QW][QW-1] ? 16'hFFFF : div_q[QW][15:0];

endmodule

>>> rtl/yabd_box.sv
module yabd_box (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  yabd_pkg::meta_t     meta,
  input  yabd_pkg::sig_set_t  sig,
  input  yabd_pkg::cfg_t      cfg,
  output logic                res_vld,
  output yabd_pkg::det_t      res
);
  import yabd_pkg::*;

  typedef struct packed {
    logic        pass;
    logic [15:0] conf;
    logic        cls;
    logic [15:0] score;
  } tag_t;

  // magnitude rounded half away from zero from Q.44, sign on top
  function automatic logic [21:0] rnd44(input logic signed [64:0] v);
    logic [64:0] m;
    m = (v ^ {65{v[64]}}) + ((65'd1 << 43) | 65'(v[64]));
    return {v[64], m[64:44]};
  endfunction

  function automatic logic signed [15:0] sat16(input logic [21:0] nq);
    logic [20:0]        q;
    logic signed [15:0] r;
    q = nq[20:0];
    if (!nq[21]) begin
      r = (q > 21'd32767) ? 16'sh7FFF : $signed(q[15:0]);
    end else begin
      r = (q > 21'd32768) ? 16'sh8000 : $signed(16'(~q[15:0] + 16'd1));
    end
    return r;
  endfunction

  logic               cls1_wins;
  logic [2:0]         shamt;
  logic signed [25:0] bx, by;
  tag_t               tag_in;

  logic               vld1, vld2, vld3, vld4, vld5;
  tag_t               tag1, tag2, tag3, tag4, tag5;
  logic [31:0]        sqw1, sqh1;
  logic [8:0]         aw1, ah1;
  logic signed [30:0] cx1, cy1, cx2, cy2;
  logic [41:0]        hw2, hh2;
  logic signed [47:0] l3, t3, r3, b3;
  logic signed [16:0] scx, scy;
  logic signed [64:0] l4, t4, r4, b4;
  logic [21:0]        l5, t5, r5, b5;

  // stage 1 inputs: threshold, class choice, centre in Q.16
  always_comb begin
    cls1_wins    = (NUM_CLASSES >= 2) && (sig.cls1 > sig.cls0);
    tag_in.pass  = meta.ok && (sig.obj >= cfg.conf_threshold);
    tag_in.conf  = sig.obj;
    tag_in.cls   = cls1_wins;
    tag_in.score = cls1_wins ? sig.cls1 : sig.cls0;
    shamt        = 3'd3 + {1'b0, meta.level};
    bx = $signed({9'd0, sig.x, 1'b0} + {3'd0, meta.col, 16'd0} - 26'd32768);
    by = $signed({9'd0, sig.y, 1'b0} + {3'd0, meta.row, 16'd0} - 26'd32768);
  end

  assign scx = $signed({1'b0, cfg.scale_x});
  assign scy = $signed({1'b0, cfg.scale_y});

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else if (en) begin
      vld1 <= in_vld;
      vld2 <= vld1;
      vld3 <= vld2;
      vld4 <= vld3;
      vld5 <= vld4;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // squares of the size sigmoids, centre scaled by stride
      tag1 <= tag_in;
      sqw1 <= 32'(sig.w) * 32'(sig.w);
      sqh1 <= 32'(sig.h) * 32'(sig.h);
      aw1  <= meta.aw;
      ah1  <= meta.ah;
      cx1  <= {{5{bx[25]}}, bx} << shamt;
      cy1  <= {{5{by[25]}}, by} << shamt;
      // half sizes in Q.32
      tag2 <= tag1;
      hw2  <= {41'(sqw1) * 41'(aw1), 1'b0};
      hh2  <= {41'(sqh1) * 41'(ah1), 1'b0};
      cx2  <= cx1;
      cy2  <= cy1;
      // corners in Q.32
      tag3 <= tag2;
      l3   <= $signed({cx2[30], cx2, 16'd0}) - $signed({6'd0, hw2});
      r3   <= $signed({cx2[30], cx2, 16'd0}) + $signed({6'd0, hw2});
      t3   <= $signed({cy2[30], cy2, 16'd0}) - $signed({6'd0, hh2});
      b3   <= $signed({cy2[30], cy2, 16'd0}) + $signed({6'd0, hh2});
      // image scaling into Q.44
      tag4 <= tag3;
      l4   <= l3 * scx;
      r4   <= r3 * scx;
      t4   <= t3 * scy;
      b4   <= b3 * scy;
      // rounding
      tag5 <= tag4;
      l5   <= rnd44(l4);
      r5   <= rnd44(r4);
      t5   <= rnd44(t4);
      b5   <= rnd44(b4);
    end
  end

  // saturation and result assembly
  assign res_vld         = vld5 && tag5.pass;
  assign res.box_left    = sat16(l5);
  assign res.box_top     = sat16(t5);
  assign res.box_right   = sat16(r5);
  assign res.box_bottom  = sat16(b5);
  assign res.confidence  = tag5.conf;
  assign res.top_class   = tag5.cls;
  assign res.class_score = tag5.score;

endmodule

>>> rtl/yolo_anchor_box_decode.sv
// each beat passes the sigmoid pipes, box stages and output register
// throughput: one prediction per cycle while the skid stage is empty, set by
// the 24-stage sigmoid pipes and the six geometry and output stages; beats
// below threshold vanish; the skid stage keeps input ready until it fills
// reset (rst, synchronous): all valid bits cleared, threshold 0.25, scales 1.0
module yolo_anchor_box_decode (
  input  logic                        clk,
  input  logic                        rst,
  yabd_pred_if.sink                   pred,
  yabd_det_if.source                  det,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [yabd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import yabd_pkg::*;

  localparam logic [7:0] GRID_L0 = 8'(MAX_GRID);
  localparam logic [7:0] GRID_L1 = 8'(MAX_GRID >> 1);
  localparam logic [7:0] GRID_L2 = 8'(MAX_GRID >> 2);

  cfg_t       cfg;
  logic       en;
  logic       level_ok, slot_ok;
  logic [7:0] grid;
  meta_t      meta_in;

  meta_t              meta_pipe [SIG_LAT];
  logic [SIG_LAT-1:0] vld_pipe;

  logic [15:0] raw_in  [7];
  logic [15:0] sig_out [7];
  sig_set_t    sig_set;

  logic  p_vld;
  det_t  p_data;
  logic  out_vld, skid_vld;
  det_t  out_data, skid_data;

  yabd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // whole pipeline moves unless the skid stage holds a beat
  assign en         = !skid_vld;
  assign pred.ready = en;

  // range checks and anchor lookup on the incoming beat
  always_comb begin
    level_ok = int'(pred.level) < NUM_LEVELS;
    slot_ok  = (int'(pred.anchor_slot) < NUM_ANCHORS) && (pred.anchor_slot <= 2'd2);
    case (pred.level)
      2'd0:    grid = GRID_L0;
      2'd1:    grid = GRID_L1;
      2'd2:    grid = GRID_L2;
      default: grid = '0;
    endcase
    meta_in.ok    = level_ok && slot_ok && ({1'b0, pred.cell_row} < grid)
                    && ({1'b0, pred.cell_col} < grid);
    meta_in.level = pred.level;
    meta_in.row   = pred.cell_row;
    meta_in.col   = pred.cell_col;
    meta_in.aw    = '0;
    meta_in.ah    = '0;
    if (level_ok && slot_ok) begin
      meta_in.aw = ANCHOR_W[pred.level][pred.anchor_slot];
      meta_in.ah = ANCHOR_H[pred.level][pred.anchor_slot];
    end
  end

  // side data delay line matching the sigmoid latency
  always_ff @(posedge clk) begin
    if (en) begin
      meta_pipe[0] <= meta_in;
      for (int i = 1; i < SIG_LAT; i++) begin
        meta_pipe[i] <= meta_pipe[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else if (en) begin
      vld_pipe <= {vld_pipe[SIG_LAT-2:0], pred.valid};
    end
  end

  // seven sigmoid pipes in parallel
  assign raw_in[0] = pred.logit_x;
  assign raw_in[1] = pred.logit_y;
  assign raw_in[2] = pred.logit_w;
  assign raw_in[3] = pred.logit_h;
  assign raw_in[4] = pred.logit_obj;
  assign raw_in[5] = pred.logit_cls0;
  assign raw_in[6] = pred.logit_cls1;

  for (genvar g = 0; g < 7; g++) begin : g_sig
    yabd_sigmoid u_sig (
      .clk (clk),
      .en  (en),
      .raw (raw_in[g]),
      .sig (sig_out[g])
    );
  end

  assign sig_set.x    = sig_out[0];
  assign sig_set.y    = sig_out[1];
  assign sig_set.w    = sig_out[2];
  assign sig_set.h    = sig_out[3];
  assign sig_set.obj  = sig_out[4];
  assign sig_set.cls0 = sig_out[5];
  assign sig_set.cls1 = sig_out[6];

  yabd_box u_box (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (vld_pipe[SIG_LAT-1]),
    .meta    (meta_pipe[SIG_LAT-1]),
    .sig     (sig_set),
    .cfg     (cfg),
    .res_vld (p_vld),
    .res     (p_data)
  );

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || det.ready) begin
      out_vld  <= skid_vld || p_vld;
      skid_vld <= 1'b0;
    end else if (p_vld && en) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld || det.ready) begin
      out_data <= skid_vld ? skid_data : p_data;
    end
    if (!skid_vld && out_vld && !det.ready) begin
      skid_data <= p_data;
    end
  end

  assign det.valid       = out_vld;
  assign det.box_left    = out_data.box_left;
  assign det.box_top     = out_data.box_top;
  assign det.box_right   = out_data.box_right;
  assign det.box_bottom  = out_data.box_bottom;
  assign det.confidence  = out_data.confidence;
  assign det.top_class   = out_data.top_class;
  assign det.class_score = out_data.class_score;

endmodule
